### src/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released
`define ACE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define ACE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ace_pkg.sv
// Shared types and constants of the assignment chromosome evaluator
package ace_pkg;

	localparam int MAX_OPERATORS_DEF = 16;
	localparam int MAX_MACHINES_DEF  = 8;
	localparam int PROFIT_BITS_DEF   = 8;

	localparam int FIT_W  = 12;
	localparam int LOAD_W = 5;
	localparam int CAP_W  = 8;
	localparam int CFG_W  = 4;

	localparam logic [FIT_W-1:0]  FIT_MAX        = '1;
	localparam logic [LOAD_W-1:0] LOAD_MAX       = '1;
	localparam logic [CFG_W-1:0]  MACHINES_RESET = 4'd5;

	typedef enum logic [1:0] {
		CMD_PROFIT   = 2'd0,
		CMD_CAPACITY = 2'd1,
		CMD_GENE     = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_BAD_GENE = 3'd1,
		VERDICT_EMPTY    = 3'd2,
		VERDICT_OVER_CAP = 3'd3,
		VERDICT_TOO_MANY = 3'd4
	} verdict_t;

	typedef struct packed {
		logic        is_gene;
		logic        is_cap;
		logic        last;
		logic        overflow;
		logic        good;
		logic [3:0]  mach_idx;
		logic [7:0]  value;
	} item_t;

endpackage

### src/ace_front.sv
// Input stage: gene classification, gene position count and profit table
module ace_front import ace_pkg::*; #(
	parameter int MAX_OPERATORS = MAX_OPERATORS_DEF,
	parameter int MAX_MACHINES  = MAX_MACHINES_DEF,
	parameter int PROFIT_BITS   = PROFIT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             cmd,
	input  logic [3:0]             operator_index,
	input  logic [3:0]             machine_number,
	input  logic [7:0]             load_value,
	input  logic                   last_gene,
	input  logic [CFG_W-1:0]       machines_in_use,
	input  logic                   s1_fire,
	output logic                   s1_valid,
	output item_t                  item_s1,
	output logic [PROFIT_BITS-1:0] profit_s1
);

	localparam int DEPTH  = MAX_OPERATORS * MAX_MACHINES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = $clog2(MAX_OPERATORS + 1);

	logic [PROFIT_BITS-1:0] profit_mem [DEPTH];
	logic [POS_W-1:0]       pos_q;
	logic                   s1_valid_q;

	logic              accept;
	logic              is_gene;
	logic              mach_in_range;
	logic              gene_good;
	logic              overflow;
	logic              prof_wr;
	logic              rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign in_ready = !s1_valid_q || s1_fire;
	assign accept   = in_valid && in_ready;
	assign s1_valid = s1_valid_q;

	assign is_gene       = cmd == CMD_GENE;
	assign mach_in_range = (machine_number != 4'd0) && (int'(machine_number) <= MAX_MACHINES);
	assign gene_good     = mach_in_range && (machine_number <= machines_in_use);
	assign overflow      = pos_q == POS_W'(MAX_OPERATORS);

	assign prof_wr = accept && (cmd == CMD_PROFIT) && (int'(operator_index) < MAX_OPERATORS)
		&& mach_in_range;
	assign rd_en   = accept && is_gene && gene_good && !overflow;
	assign wr_addr = ADDR_W'(int'(operator_index) * MAX_MACHINES + int'(machine_number) - 1);
	assign rd_addr = ADDR_W'(int'(pos_q) * MAX_MACHINES + int'(machine_number) - 1);

	always_ff @(posedge clk) begin
		if (prof_wr) begin
			profit_mem[wr_addr] <= PROFIT_BITS'(load_value);
		end
		if (rd_en) begin
			profit_s1 <= profit_mem[rd_addr];
		end
	end

	// advance the gene position; restart after the final gene
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept && is_gene) begin
				if (last_gene) begin
					pos_q <= '0;
				end else if (!overflow) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.is_gene  <= is_gene;
			item_s1.is_cap   <= (cmd == CMD_CAPACITY) && mach_in_range;
			item_s1.last     <= last_gene;
			item_s1.overflow <= overflow;
			item_s1.good     <= gene_good;
			item_s1.mach_idx <= machine_number - 4'd1;
			item_s1.value    <= load_value;
		end
	end

endmodule

### src/ace_eval.sv
// Evaluation stage: fitness sum, machine loads, capacities, verdict and result register
module ace_eval import ace_pkg::*; #(
	parameter int MAX_MACHINES = MAX_MACHINES_DEF,
	parameter int PROFIT_BITS  = PROFIT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CFG_W-1:0]       machines_in_use,
	input  logic                   s1_valid,
	input  item_t                  item_s1,
	input  logic [PROFIT_BITS-1:0] profit_s1,
	output logic                   s1_fire,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FIT_W-1:0]       fitness,
	output logic                   feasible,
	output logic [2:0]             verdict
);

	localparam int SUM_W = ((FIT_W > PROFIT_BITS) ? FIT_W : PROFIT_BITS) + 1;

	logic [LOAD_W-1:0] load_q [MAX_MACHINES];
	logic [CAP_W-1:0]  cap_q  [MAX_MACHINES];
	logic [FIT_W-1:0]  fit_q;
	logic              bad_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [FIT_W-1:0]  fitness_q;
	logic              feasible_q;
	verdict_t          verdict_q;

	logic [LOAD_W-1:0] load_next [MAX_MACHINES];
	logic [FIT_W-1:0]  fit_next;
	logic [SUM_W-1:0]  sum;
	logic              bad_next;
	logic              ovf_next;
	logic              take;
	logic              finish;
	verdict_t          verdict_next;

	assign finish  = item_s1.is_gene && item_s1.last;
	assign s1_fire = s1_valid && (!finish || !out_valid_q || out_ready);
	assign take    = item_s1.is_gene && item_s1.good && !item_s1.overflow;
	assign sum     = SUM_W'(fit_q) + SUM_W'(profit_s1);

	assign fit_next = !take ? fit_q : ((sum > SUM_W'(FIT_MAX)) ? FIT_MAX : FIT_W'(sum));
	assign bad_next = bad_q || (item_s1.is_gene && !item_s1.overflow && !item_s1.good);
	assign ovf_next = ovf_q || (item_s1.is_gene && item_s1.overflow);

	always_comb begin
		for (int j = 0; j < MAX_MACHINES; j++) begin
			load_next[j] = load_q[j];
			if (take && (int'(item_s1.mach_idx) == j) && (load_q[j] != LOAD_MAX)) begin
				load_next[j] = load_q[j] + 1'b1;
			end
		end
	end

	// lowest machine wins: scan downwards and overwrite
	always_comb begin
		verdict_next = VERDICT_OK;
		for (int j = MAX_MACHINES - 1; j >= 0; j--) begin
			if (j < int'(machines_in_use)) begin
				if (load_next[j] == '0) begin
					verdict_next = VERDICT_EMPTY;
				end else if (CAP_W'(load_next[j]) > cap_q[j]) begin
					verdict_next = VERDICT_OVER_CAP;
				end
			end
		end
		if (bad_next) begin
			verdict_next = VERDICT_BAD_GENE;
		end
		if (ovf_next) begin
			verdict_next = VERDICT_TOO_MANY;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_MACHINES; j++) begin
			if (s1_fire && item_s1.is_cap && (int'(item_s1.mach_idx) == j)) begin
				cap_q[j] <= item_s1.value;
			end
		end
	end

	// commit the gene, or drop the chromosome state after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_MACHINES; j++) begin
				load_q[j] <= '0;
			end
			fit_q       <= '0;
			bad_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire && item_s1.is_gene) begin
				for (int j = 0; j < MAX_MACHINES; j++) begin
					load_q[j] <= finish ? '0 : load_next[j];
				end
				fit_q <= finish ? '0 : fit_next;
				bad_q <= finish ? 1'b0 : bad_next;
				ovf_q <= finish ? 1'b0 : ovf_next;
			end
			if (s1_fire && finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && finish) begin
			fitness_q  <= fit_next;
			feasible_q <= verdict_next == VERDICT_OK;
			verdict_q  <= verdict_next;
		end
	end

	assign out_valid = out_valid_q;
	assign fitness   = fitness_q;
	assign feasible  = feasible_q;
	assign verdict   = verdict_q;

endmodule

### src/assignment_chromosome_evaluator.sv
// Top level of the assignment chromosome evaluator
// Takes one transaction per cycle: profit loads, capacity loads and genes alike. An accepted
// transaction is registered with its profit table read, then the evaluation stage adds the
// profit, counts the machine load and, on the final gene, registers fitness, feasible flag and
// verdict, so a result is valid once the evaluation stage takes its final gene from the input
// register. The rate is set by the profit memory read and the state update in the evaluation
// stage; input stalls only while a result waits unaccepted and the next final gene already
// sits in the input register. The profit and capacity tables are not cleared at reset and
// must be loaded before use. Write machines_in_use only while no transaction is in flight.
module assignment_chromosome_evaluator import ace_pkg::*; #(
	parameter int MAX_OPERATORS = MAX_OPERATORS_DEF,
	parameter int MAX_MACHINES  = MAX_MACHINES_DEF,
	parameter int PROFIT_BITS   = PROFIT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic [3:0]       operator_index,
	input  logic [3:0]       machine_number,
	input  logic [7:0]       load_value,
	input  logic             last_gene,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [FIT_W-1:0] fitness,
	output logic             feasible,
	output logic [2:0]       verdict
);

	logic [CFG_W-1:0]       machines_in_use_q;
	logic                   s1_fire;
	logic                   s1_valid;
	item_t                  item_s1;
	logic [PROFIT_BITS-1:0] profit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			machines_in_use_q <= MACHINES_RESET;
		end else if (cfg_we) begin
			machines_in_use_q <= cfg_wdata;
		end
	end

	ace_front #(
		.MAX_OPERATORS (MAX_OPERATORS),
		.MAX_MACHINES  (MAX_MACHINES),
		.PROFIT_BITS   (PROFIT_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.operator_index  (operator_index),
		.machine_number  (machine_number),
		.load_value      (load_value),
		.last_gene       (last_gene),
		.machines_in_use (machines_in_use_q),
		.s1_fire         (s1_fire),
		.s1_valid        (s1_valid),
		.item_s1         (item_s1),
		.profit_s1       (profit_s1)
	);

	ace_eval #(
		.MAX_MACHINES (MAX_MACHINES),
		.PROFIT_BITS  (PROFIT_BITS)
	) u_eval (
		.clk             (clk),
		.arst_n          (arst_n),
		.machines_in_use (machines_in_use_q),
		.s1_valid        (s1_valid),
		.item_s1         (item_s1),
		.profit_s1       (profit_s1),
		.s1_fire         (s1_fire),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fitness         (fitness),
		.feasible        (feasible),
		.verdict         (verdict)
	);

endmodule

### src/ace_checker.sv
// Port-level checker of the assignment chromosome evaluator, bound to the top level
`include "assert_macros.svh"

module ace_checker import ace_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [FIT_W-1:0] fitness,
	input logic             feasible,
	input logic [2:0]       verdict
);

	property p_out_hold;
		out_valid && !out_ready |=> out_valid && $stable(fitness) && $stable(feasible)
			&& $stable(verdict);
	endproperty

	property p_feasible;
		out_valid |-> (feasible == (verdict == VERDICT_OK));
	endproperty

	property p_verdict_code;
		out_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_BAD_GENE
			|| verdict == VERDICT_EMPTY || verdict == VERDICT_OVER_CAP
			|| verdict == VERDICT_TOO_MANY);
	endproperty

	property p_reset_quiet;
		!arst_n |-> !out_valid;
	endproperty

	`ACE_ASSERT(a_out_hold, clk, arst_n, p_out_hold, "result changed while stalled")
	`ACE_ASSERT(a_feasible, clk, arst_n, p_feasible, "feasible flag disagrees with verdict")
	`ACE_ASSERT(a_verdict_code, clk, arst_n, p_verdict_code, "verdict code out of range")
	`ACE_ASSERT_ALWAYS(a_reset_quiet, clk, p_reset_quiet, "result valid during reset")

endmodule

bind assignment_chromosome_evaluator ace_checker u_ace_checker (.*);

### verif/tb.sv
// Testbench for the assignment chromosome evaluator: predicts each verdict and checks every result
module tb;
	import ace_pkg::*;

	localparam logic [1:0] CMD_SPARE   = 2'd3;
	localparam int         HOLD_CYCLES = 150;
	localparam int         QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [FIT_W-1:0] fitness;
		logic             feasible;
		verdict_t         verdict;
	} score_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       cmd;
	logic [3:0]       operator_index;
	logic [3:0]       machine_number;
	logic [7:0]       load_value;
	logic             last_gene;
	logic             out_valid;
	logic             out_ready;
	logic [FIT_W-1:0] fitness;
	logic             feasible;
	logic [2:0]       verdict;

	assignment_chromosome_evaluator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.operator_index (operator_index),
		.machine_number (machine_number),
		.load_value     (load_value),
		.last_gene      (last_gene),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fitness        (fitness),
		.feasible       (feasible),
		.verdict        (verdict)
	);

	logic [PROFIT_BITS_DEF-1:0] profit_mem [MAX_OPERATORS_DEF][MAX_MACHINES_DEF];
	logic [CAP_W-1:0]           capacity_mem [MAX_MACHINES_DEF];
	logic [LOAD_W-1:0]          load_count [MAX_MACHINES_DEF];
	logic [FIT_W-1:0]           fitness_sum   = '0;
	int                         gene_count    = 0;
	logic                       bad_gene_flag = 1'b0;
	logic                       overflow_flag = 1'b0;
	logic [CFG_W-1:0]           machines_cfg  = MACHINES_RESET;

	score_t pending_scores[$];
	score_t want;
	int     chrom[$];
	int     mismatches   = 0;
	int     sent_count   = 0;
	int     burst_left   = 0;
	int     quiet_cycles = 0;
	bit     hold_request = 1'b0;
	int     hold_left    = 0;
	int     ready_mode   = 0;
	int     mode_left    = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		for (int j = 0; j < MAX_MACHINES_DEF; j++)
			load_count[j] = '0;
	end

	function automatic int active_machines();
		return (machines_cfg > MAX_MACHINES_DEF) ? MAX_MACHINES_DEF : int'(machines_cfg);
	endfunction

	function automatic void add_gene(input int g);
		chrom.insert(chrom.size(), g);
	endfunction

	task automatic score_transaction(input logic [1:0] c, input logic [3:0] op,
			input logic [3:0] mach, input logic [7:0] val, input logic last);
		int       m_eff;
		int       sum;
		verdict_t v;
		score_t   s;
		m_eff = active_machines();
		case (c)
		CMD_PROFIT: begin
			if (op < MAX_OPERATORS_DEF && mach >= 1 && mach <= MAX_MACHINES_DEF)
				profit_mem[op][mach - 1] = val[PROFIT_BITS_DEF-1:0];
		end
		CMD_CAPACITY: begin
			if (mach >= 1 && mach <= MAX_MACHINES_DEF)
				capacity_mem[mach - 1] = val;
		end
		CMD_GENE: begin
			if (gene_count >= MAX_OPERATORS_DEF) begin
				overflow_flag = 1'b1;
			end else begin
				if (mach < 1 || int'(mach) > m_eff) begin
					bad_gene_flag = 1'b1;
				end else begin
					sum = int'(fitness_sum) + int'(profit_mem[gene_count][mach - 1]);
					fitness_sum = (sum > int'(FIT_MAX)) ? FIT_MAX : sum[FIT_W-1:0];
					if (load_count[mach - 1] < LOAD_MAX)
						load_count[mach - 1] = load_count[mach - 1] + 1'b1;
				end
				gene_count++;
			end
			if (last) begin
				v = VERDICT_OK;
				if (overflow_flag)
					v = VERDICT_TOO_MANY;
				else if (bad_gene_flag)
					v = VERDICT_BAD_GENE;
				else
					for (int j = 0; j < m_eff; j++)
						if (v == VERDICT_OK) begin
							if (load_count[j] == 0)
								v = VERDICT_EMPTY;
							else if (CAP_W'(load_count[j]) > capacity_mem[j])
								v = VERDICT_OVER_CAP;
						end
				s.fitness  = fitness_sum;
				s.feasible = (v == VERDICT_OK);
				s.verdict  = v;
				pending_scores.insert(pending_scores.size(), s);
				for (int j = 0; j < MAX_MACHINES_DEF; j++)
					load_count[j] = '0;
				fitness_sum   = '0;
				gene_count    = 0;
				bad_gene_flag = 1'b0;
				overflow_flag = 1'b0;
			end
		end
		default: ;
		endcase
	endtask

	task automatic send_txn(input logic [1:0] c, input logic [3:0] op, input logic [3:0] mach,
			input logic [7:0] val, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid       <= 1'b1;
		cmd            <= c;
		operator_index <= op;
		machine_number <= mach;
		load_value     <= val;
		last_gene      <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		score_transaction(c, op, mach, val, last);
		sent_count++;
	endtask

	task automatic send_chromosome();
		for (int k = 0; k < chrom.size(); k++)
			send_txn(CMD_GENE, 4'($urandom_range(0, 15)), 4'(chrom[k]),
				8'($urandom_range(0, 255)), k == chrom.size() - 1);
	endtask

	task automatic write_machines(input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		machines_cfg  = value;
	endtask

	task automatic build_cover(input int m_eff, input int max_len);
		int len;
		int j;
		int tmp;
		chrom.delete();
		if (m_eff == 0) begin
			len = $urandom_range(1, 6);
			repeat (len) add_gene($urandom_range(0, 15));
			return;
		end
		len = $urandom_range(m_eff, max_len);
		for (int k = 1; k <= m_eff; k++)
			add_gene(k);
		while (chrom.size() < len)
			add_gene($urandom_range(1, m_eff));
		for (int k = chrom.size() - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = chrom[k];
			chrom[k] = chrom[j];
			chrom[j] = tmp;
		end
	endtask

	function automatic logic [3:0] stray_machine();
		return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
	endfunction

	function automatic int bad_gene(input int m_eff);
		if (m_eff == 0)
			return $urandom_range(0, 15);
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(m_eff + 1, 15);
	endfunction

	task automatic reload_capacities(input int style);
		logic [7:0] val;
		for (int k = 1; k <= MAX_MACHINES_DEF; k++) begin
			case (style)
			0:       val = 8'($urandom_range(0, 3));
			1:       val = 8'($urandom_range(8, 255));
			default: val = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 6));
			endcase
			send_txn(CMD_CAPACITY, 4'($urandom_range(0, 15)), 4'(k), val,
				1'($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 2) == 0)
			send_txn(CMD_CAPACITY, 4'($urandom_range(0, 15)), stray_machine(),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_table_fill();
		logic [7:0] val;
		for (int op = 0; op < MAX_OPERATORS_DEF; op++)
			for (int m = 1; m <= MAX_MACHINES_DEF; m++) begin
				case (op % 3)
				0:       val = 8'hFF;
				1:       val = 8'h00;
				default: val = 8'($urandom_range(0, 255));
				endcase
				send_txn(CMD_PROFIT, 4'(op), 4'(m), val, 1'($urandom_range(0, 1)));
			end
		for (int m = 1; m <= MAX_MACHINES_DEF; m++)
			send_txn(CMD_CAPACITY, 4'd0, 4'(m), 8'd3, 1'b0);
		send_txn(CMD_PROFIT, 4'd15, 4'd0, 8'hAA, 1'b1);
		send_txn(CMD_PROFIT, 4'd7, 4'd9, 8'hAA, 1'b0);
		send_txn(CMD_PROFIT, 4'd0, 4'd15, 8'hAA, 1'b1);
		send_txn(CMD_CAPACITY, 4'd15, 4'd0, 8'd0, 1'b1);
		send_txn(CMD_CAPACITY, 4'd0, 4'd9, 8'd0, 1'b0);
		send_txn(CMD_CAPACITY, 4'd0, 4'd15, 8'd0, 1'b1);
	endtask

	task automatic test_verdict_cases();
		chrom = '{1, 2, 3, 4, 5};
		send_chromosome();
		chrom = '{0};
		send_chromosome();
		chrom = '{15};
		send_chromosome();
		chrom = '{5};
		send_chromosome();
		send_txn(CMD_CAPACITY, 4'd0, 4'd3, 8'd0, 1'b0);
		chrom = '{1, 2, 3, 4, 5};
		send_chromosome();
		send_txn(CMD_CAPACITY, 4'd0, 4'd3, 8'd3, 1'b0);
		send_txn(CMD_SPARE, 4'd15, 4'd15, 8'hFF, 1'b1);
		chrom.delete();
		for (int k = 0; k < MAX_OPERATORS_DEF + 1; k++)
			add_gene(k % 5 + 1);
		send_chromosome();
	endtask

	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (40) begin
			chrom = '{$urandom_range(0, 15)};
			send_chromosome();
		end
	endtask

	task automatic test_random_phase(input logic [CFG_W-1:0] machines, input int quota);
		int m_eff;
		int style;
		int start;
		int pick;
		int n;
		int g;
		int skip;
		write_machines(machines);
		m_eff = active_machines();
		style = $urandom_range(0, 2);
		reload_capacities(style);
		start = sent_count;
		while (sent_count - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				build_cover(m_eff, MAX_OPERATORS_DEF);
				send_chromosome();
			end else if (pick < 75) begin
				case ($urandom_range(0, 2))
				0: begin
					build_cover(m_eff, MAX_OPERATORS_DEF - 1);
					chrom.insert($urandom_range(0, chrom.size()), bad_gene(m_eff));
				end
				1: begin
					chrom.delete();
					n = $urandom_range(MAX_OPERATORS_DEF + 1, MAX_OPERATORS_DEF + 4);
					repeat (n)
						add_gene(m_eff == 0 ? $urandom_range(0, 15) : $urandom_range(1, m_eff));
				end
				default: begin
					chrom.delete();
					n = $urandom_range(1, MAX_OPERATORS_DEF);
					if (m_eff >= 2) begin
						skip = $urandom_range(1, m_eff);
						repeat (n) begin
							g = $urandom_range(1, m_eff - 1);
							if (g >= skip)
								g++;
							add_gene(g);
						end
					end else begin
						repeat (n) add_gene($urandom_range(0, 15));
					end
				end
				endcase
				send_chromosome();
			end else if (pick < 83) begin
				reload_capacities(style);
			end else if (pick < 95) begin
				n = $urandom_range(1, 12);
				repeat (n)
					send_txn(CMD_PROFIT, 4'($urandom_range(0, 15)),
						($urandom_range(0, 7) == 0) ? stray_machine() : 4'($urandom_range(1, 8)),
						($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end else begin
				send_txn(CMD_SPARE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(40, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (ready_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 1) == 1);
				2:       out_ready <= ($urandom_range(0, 9) == 0);
				default: out_ready <= (mode_left % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_scores.size() == 0) begin
				$display("%0t: unexpected result fitness %0d feasible %0d verdict %0d",
					$time, fitness, feasible, verdict);
				mismatches++;
			end else begin
				want = pending_scores.pop_front();
				if (fitness !== want.fitness) begin
					$display("%0t: fitness expected %0d actual %0d", $time, want.fitness, fitness);
					mismatches++;
				end
				if (feasible !== want.feasible) begin
					$display("%0t: feasible expected %0d actual %0d", $time, want.feasible, feasible);
					mismatches++;
				end
				if (verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d actual %0d", $time, want.verdict, verdict);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		in_valid       <= 1'b0;
		cmd            <= '0;
		operator_index <= '0;
		machine_number <= '0;
		load_value     <= '0;
		last_gene      <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_verdict_cases();
		test_output_backpressure();
		test_random_phase(4'd8, 100);
		test_random_phase(4'd1, 100);
		test_random_phase(4'd0, 100);
		test_random_phase(4'd15, 100);
		test_random_phase(4'd3, 100);
		test_random_phase(4'd2, 100);
		test_random_phase(4'd12, 100);
		test_random_phase(4'd7, 100);
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/ace_pkg.sv
src/ace_front.sv
src/ace_eval.sv
src/assignment_chromosome_evaluator.sv
src/ace_checker.sv
verif/tb.sv
